// ----- src/sfd_pkg.sv -----
// Shared types and constants for the SLIP frame decoder.
package sfd_pkg;

	// Width of the frame length counter
	localparam int LEN_WIDTH = 16;
	// Width of the configured frame size limit
	localparam int MAX_SIZE_WIDTH = 16;
	// Compare width covering both the limit and the counter plus one
	localparam int CMP_WIDTH = ((LEN_WIDTH > MAX_SIZE_WIDTH) ? LEN_WIDTH : MAX_SIZE_WIDTH) + 1;

	// SLIP special bytes
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	// Configuration register indexes
	localparam int CFG_IDX_WIDTH = 2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_FRAME_SIZE    = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_DROP_UNTIL_END    = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ALLOW_EMPTY_FRAME = 2'd2;

	// Configuration reset values
	localparam logic [MAX_SIZE_WIDTH-1:0] MAX_FRAME_SIZE_RST = 16'd1006;
	localparam logic DROP_UNTIL_END_RST    = 1'b1;
	localparam logic ALLOW_EMPTY_FRAME_RST = 1'b0;

	// Decoder modes
	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_FRAME     = 3'd1,
		MODE_ESCP      = 3'd2,
		MODE_DRAIN_BAD = 3'd3,
		MODE_DRAIN_BIG = 3'd4
	} mode_t;

	// Result events
	typedef enum logic [2:0] {
		EV_DATA      = 3'd0,
		EV_FRAME_END = 3'd1,
		EV_BAD_ESC   = 3'd2,
		EV_NO_DELIM  = 3'd3,
		EV_OVERSIZE  = 3'd4
	} event_t;

	// One result item
	typedef struct packed {
		logic [7:0] data;
		event_t     ev;
	} result_t;

endpackage

// ----- src/slip_frame_decoder.sv -----
// Top level of the byte-serial SLIP receive decoder.
// Each result is registered in the output register, or in the skid register while the output stalls.
// One byte per cycle while the skid register is empty; the mode machine and length compare are combinational.
// A skid register keeps input transfers going for one result while the output stalls.
// Reset (arst_n low, asynchronous) returns the decoder to idle with an empty output
// and restores the registers to 1006, 1 and 0.
module slip_frame_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            rx_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [7:0]                            out_byte,
	output logic [2:0]                            event_res,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sfd_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [sfd_pkg::MAX_SIZE_WIDTH-1:0]    cfg_data
);

	// Configuration registers
	logic [sfd_pkg::MAX_SIZE_WIDTH-1:0] max_frame_size_q;
	logic                               drop_until_end_q;
	logic                               allow_empty_frame_q;

	// Decoder state
	sfd_pkg::mode_t                mode_q, mode_d;
	logic [sfd_pkg::LEN_WIDTH-1:0] len_q, len_d;
	logic                          seen_q, seen_d;

	// Output and skid registers
	logic              out_valid_q;
	sfd_pkg::result_t  out_q;
	logic              skid_valid_q;
	sfd_pkg::result_t  skid_q;

	// Per-byte decode
	logic                          in_xfer;
	logic                          is_payload;
	logic [7:0]                    pay_byte;
	logic [sfd_pkg::CMP_WIDTH-1:0] limit;
	logic [sfd_pkg::CMP_WIDTH-1:0] len_next;
	logic                          over;
	logic                          res_valid;
	sfd_pkg::result_t              res;
	logic                          out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_q.data;
	assign event_res = out_q.ev;

	// Write configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_size_q    <= sfd_pkg::MAX_FRAME_SIZE_RST;
			drop_until_end_q    <= sfd_pkg::DROP_UNTIL_END_RST;
			allow_empty_frame_q <= sfd_pkg::ALLOW_EMPTY_FRAME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfd_pkg::CFG_MAX_FRAME_SIZE:    max_frame_size_q    <= cfg_data;
				sfd_pkg::CFG_DROP_UNTIL_END:    drop_until_end_q    <= cfg_data[0];
				sfd_pkg::CFG_ALLOW_EMPTY_FRAME: allow_empty_frame_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pick the payload byte: resolved escape or plain byte in a frame
	always_comb begin
		is_payload = 1'b0;
		pay_byte   = rx_byte;
		case (mode_q)
			sfd_pkg::MODE_ESCP: begin
				if (rx_byte == sfd_pkg::SLIP_ESC_END) begin
					is_payload = 1'b1;
					pay_byte   = sfd_pkg::SLIP_END;
				end else if (rx_byte == sfd_pkg::SLIP_ESC_ESC) begin
					is_payload = 1'b1;
					pay_byte   = sfd_pkg::SLIP_ESC;
				end
			end
			sfd_pkg::MODE_FRAME: begin
				is_payload = (rx_byte != sfd_pkg::SLIP_END) && (rx_byte != sfd_pkg::SLIP_ESC);
			end
			default: ;
		endcase
	end

	// Effective limit is the smaller of the register and the counter capacity
	always_comb begin
		logic [sfd_pkg::CMP_WIDTH-1:0] cfg_lim;
		logic [sfd_pkg::CMP_WIDTH-1:0] cap;
		cfg_lim  = sfd_pkg::CMP_WIDTH'(max_frame_size_q);
		cap      = sfd_pkg::CMP_WIDTH'({sfd_pkg::LEN_WIDTH{1'b1}});
		limit    = (cfg_lim > cap) ? cap : cfg_lim;
		len_next = sfd_pkg::CMP_WIDTH'(len_q) + sfd_pkg::CMP_WIDTH'(1);
		over     = len_next > limit;
	end

	// Next state of the mode machine
	always_comb begin
		mode_d = mode_q;
		len_d  = len_q;
		seen_d = seen_q;
		case (mode_q)
			sfd_pkg::MODE_DRAIN_BAD, sfd_pkg::MODE_DRAIN_BIG: begin
				if (rx_byte == sfd_pkg::SLIP_END) begin
					mode_d = sfd_pkg::MODE_IDLE;
					len_d  = '0;
					seen_d = 1'b0;
				end
			end
			sfd_pkg::MODE_ESCP, sfd_pkg::MODE_FRAME: begin
				if (is_payload) begin
					if (over) begin
						mode_d = sfd_pkg::MODE_DRAIN_BIG;
					end else begin
						mode_d = sfd_pkg::MODE_FRAME;
						len_d  = len_next[sfd_pkg::LEN_WIDTH-1:0];
						seen_d = 1'b1;
					end
				end else if (mode_q == sfd_pkg::MODE_FRAME && rx_byte == sfd_pkg::SLIP_ESC) begin
					mode_d = sfd_pkg::MODE_ESCP;
				end else if (mode_q == sfd_pkg::MODE_ESCP && drop_until_end_q) begin
					mode_d = sfd_pkg::MODE_DRAIN_BAD;
				end else begin
					// frame close, or bad escape with no draining
					mode_d = sfd_pkg::MODE_IDLE;
					len_d  = '0;
					seen_d = 1'b0;
				end
			end
			default: begin
				mode_d = (rx_byte == sfd_pkg::SLIP_END) ? sfd_pkg::MODE_FRAME : sfd_pkg::MODE_IDLE;
				len_d  = '0;
				seen_d = 1'b0;
			end
		endcase
	end

	// Result of the current byte
	always_comb begin
		res_valid = 1'b0;
		res.data  = 8'h00;
		res.ev    = sfd_pkg::EV_DATA;
		case (mode_q)
			sfd_pkg::MODE_DRAIN_BAD, sfd_pkg::MODE_DRAIN_BIG: ;
			sfd_pkg::MODE_ESCP, sfd_pkg::MODE_FRAME: begin
				if (is_payload) begin
					res_valid = 1'b1;
					if (over) begin
						res.ev = sfd_pkg::EV_OVERSIZE;
					end else begin
						res.data = pay_byte;
					end
				end else if (mode_q == sfd_pkg::MODE_ESCP) begin
					res_valid = 1'b1;
					res.ev    = sfd_pkg::EV_BAD_ESC;
				end else if (rx_byte == sfd_pkg::SLIP_END) begin
					res_valid = seen_q || allow_empty_frame_q;
					res.ev    = sfd_pkg::EV_FRAME_END;
				end
			end
			default: begin
				if (rx_byte != sfd_pkg::SLIP_END && !drop_until_end_q) begin
					res_valid = 1'b1;
					res.ev    = sfd_pkg::EV_NO_DELIM;
				end
			end
		endcase
	end

	// Advance decoder state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sfd_pkg::MODE_IDLE;
			len_q  <= '0;
			seen_q <= 1'b0;
		end else if (in_xfer) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			seen_q <= seen_d;
		end
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer && res_valid;
			end
		end else if (in_xfer && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload of the output and skid registers
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_xfer && res_valid) begin
				out_q <= res;
			end
		end else if (in_xfer && res_valid) begin
			skid_q <= res;
		end
	end

`ifndef SYNTH
	// Skid register is only filled behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output is empty");

	// Drain modes never produce a result
	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (mode_q == sfd_pkg::MODE_DRAIN_BAD || mode_q == sfd_pkg::MODE_DRAIN_BIG))
		|-> !res_valid)
		else $error("result produced while draining");

	// Length is zero whenever no payload has been seen
	a_len_with_seen: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (len_q == '0))
		else $error("frame length nonzero without payload");

	// END in idle opens a frame
	a_end_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && mode_q == sfd_pkg::MODE_IDLE && rx_byte == sfd_pkg::SLIP_END)
		|=> (mode_q == sfd_pkg::MODE_FRAME))
		else $error("END in idle did not open a frame");
`endif

endmodule
